/* design/decimal_text_to_bcd_float_parser_assert.svh */
// assertion macros for the decimal text to bcd float parser
// clocked on clk_i, reset by rst_ni in the including module
`ifndef DECIMAL_TEXT_TO_BCD_FLOAT_PARSER_ASSERT_SVH
`define DECIMAL_TEXT_TO_BCD_FLOAT_PARSER_ASSERT_SVH

`ifndef SYNTH
`define DTBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DTBP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DTBP_ASSERT(name, prop, msg)
`define DTBP_ASSERT_RST(name, prop, msg)
`endif

`endif

/* design/dtbp_pkg.sv */
// package for the decimal text to bcd float parser
// character codes, limits, status codes and the structs passed between modules
package dtbp_pkg;

  localparam int MantDigits = 16;
  localparam int MantW      = 64;
  localparam int NumNibbles = MantW / 4;
  localparam int CountW     = 5;
  localparam int DigitW     = 4;
  localparam int ExpW       = 10;
  localparam int LzW        = 8;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPoint  = 8'h2E;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharLowerE = 8'h65;
  localparam logic [7:0] CharUpperE = 8'h45;

  localparam logic [ExpW-1:0] ExpSat = 10'd1023;
  localparam logic [LzW-1:0]  LzSat  = 8'd255;
  localparam logic [6:0]      ExpMax = 7'd99;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StTooManyDig  = 2'd1,
    StExpOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic              negative;
    logic [MantW-1:0]  mantissa_bcd;
    logic              has_digits;
    logic [CountW-1:0] point_pos;
    logic [ExpW-1:0]   written_exp;
    logic              written_exp_neg;
    logic [LzW-1:0]    frac_zeros;
    logic              too_many;
  } snap_t;

  typedef struct packed {
    logic             negative;
    logic [MantW-1:0] mantissa_bcd;
    logic             exponent_negative;
    logic [3:0]       exponent_tens;
    logic [3:0]       exponent_units;
    status_e          status;
  } res_t;

endpackage

/* design/dtbp_if.sv */
// request channels of the decimal text to bcd float parser
// character channel and result channel; no dependencies
interface dtbp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface dtbp_res_if;
  logic        valid;
  logic        ready;
  logic        negative;
  logic [63:0] mantissa_bcd;
  logic        exponent_negative;
  logic [3:0]  exponent_tens;
  logic [3:0]  exponent_units;
  logic [1:0]  status;

  modport source (output valid, output negative, output mantissa_bcd,
                  output exponent_negative, output exponent_tens,
                  output exponent_units, output status, input ready);
  modport sink (input valid, input negative, input mantissa_bcd,
                input exponent_negative, input exponent_tens,
                input exponent_units, input status, output ready);
endinterface

/* design/dtbp_scan.sv */
// character scanner: parse state, digit store and per-number counters
// depends on dtbp_pkg; gives the end-of-number snapshot as dtbp_pkg::snap_t
module dtbp_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_code_i,
  input  logic            last_char_i,
  output dtbp_pkg::snap_t snap_o
);
  import dtbp_pkg::*;

  typedef enum logic [2:0] {
    PhStart     = 3'd0,
    PhMant      = 3'd1,
    PhExpSign   = 3'd2,
    PhExpDigits = 3'd3,
    PhExpDone   = 3'd4
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [DigitW-1:0]       store_q [NumNibbles];
  logic [DigitW-1:0]       store_d [NumNibbles];
  logic [CountW-1:0]       count_q, count_d;
  logic [CountW-1:0]       dbp_q, dbp_d;
  logic                    point_q, point_d;
  logic                    nz_q, nz_d;
  logic [LzW-1:0]          flz_q, flz_d;
  logic [ExpW-1:0]         wexp_q, wexp_d;
  logic                    wneg_q, wneg_d;
  logic                    sign_q, sign_d;
  logic                    err_q, err_d;

  logic                    is_digit;
  logic [DigitW-1:0]       digit;
  logic [ExpW+3:0]         exp_sum;
  logic [ExpW-1:0]         exp_next;
  logic                    mant_char;

  assign is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign digit    = DigitW'(char_code_i - CharZero);
  assign exp_sum  = {wexp_q, 3'b000} + {2'b00, wexp_q, 1'b0} + (ExpW+4)'(digit);
  assign exp_next = (exp_sum > (ExpW+4)'(ExpSat)) ? ExpSat : exp_sum[ExpW-1:0];

  always_comb begin
    phase_d   = phase_q;
    store_d   = store_q;
    count_d   = count_q;
    dbp_d     = dbp_q;
    point_d   = point_q;
    nz_d      = nz_q;
    flz_d     = flz_q;
    wexp_d    = wexp_q;
    wneg_d    = wneg_q;
    sign_d    = sign_q;
    err_d     = err_q;
    mant_char = 1'b0;
    unique case (phase_q)
      PhStart: begin
        if (char_code_i == CharMinus) begin
          sign_d  = 1'b1;
          phase_d = PhMant;
        end else if (char_code_i == CharPlus) begin
          phase_d = PhMant;
        end else begin
          mant_char = 1'b1;
        end
      end
      PhMant: mant_char = 1'b1;
      PhExpSign: begin
        if (char_code_i == CharMinus) begin
          wneg_d  = 1'b1;
          phase_d = PhExpDigits;
        end else if (char_code_i == CharPlus) begin
          phase_d = PhExpDigits;
        end else if (is_digit) begin
          wexp_d  = exp_next;
          phase_d = PhExpDigits;
        end else begin
          phase_d = PhExpDone;
        end
      end
      PhExpDigits: begin
        if (is_digit) begin
          wexp_d = exp_next;
        end else begin
          phase_d = PhExpDone;
        end
      end
      PhExpDone: ;
      default: ;
    endcase

    if (mant_char) begin
      if (char_code_i == CharLowerE || char_code_i == CharUpperE) begin
        phase_d = PhExpSign;
      end else begin
        phase_d = PhMant;
        if (char_code_i == CharPoint) begin
          point_d = 1'b1;
          dbp_d   = count_q;
        end else if (is_digit) begin
          if (digit == '0 && !nz_q) begin
            if (point_q && flz_q != LzSat) begin
              flz_d = flz_q + LzW'(1);
            end
          end else begin
            nz_d = 1'b1;
            if (count_q >= CountW'(MantDigits)) begin
              err_d = 1'b1;
            end else begin
              store_d[count_q[CountW-2:0]] = digit;
              count_d = count_q + CountW'(1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    snap_o.negative        = sign_d;
    for (int i = 0; i < NumNibbles; i++) begin
      snap_o.mantissa_bcd[MantW-1-DigitW*i -: DigitW] = store_d[i];
    end
    snap_o.has_digits      = (count_d != '0);
    snap_o.point_pos       = point_d ? dbp_d : count_d;
    snap_o.written_exp     = wexp_d;
    snap_o.written_exp_neg = wneg_d;
    snap_o.frac_zeros      = flz_d;
    snap_o.too_many        = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      for (int i = 0; i < NumNibbles; i++) begin
        store_q[i] <= '0;
      end
      count_q <= '0;
      dbp_q   <= '0;
      point_q <= 1'b0;
      nz_q    <= 1'b0;
      flz_q   <= '0;
      wexp_q  <= '0;
      wneg_q  <= 1'b0;
      sign_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i && last_char_i) begin
      phase_q <= PhStart;
      for (int i = 0; i < NumNibbles; i++) begin
        store_q[i] <= '0;
      end
      count_q <= '0;
      dbp_q   <= '0;
      point_q <= 1'b0;
      nz_q    <= 1'b0;
      flz_q   <= '0;
      wexp_q  <= '0;
      wneg_q  <= 1'b0;
      sign_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      store_q <= store_d;
      count_q <= count_d;
      dbp_q   <= dbp_d;
      point_q <= point_d;
      nz_q    <= nz_d;
      flz_q   <= flz_d;
      wexp_q  <= wexp_d;
      wneg_q  <= wneg_d;
      sign_q  <= sign_d;
      err_q   <= err_d;
    end
  end

endmodule

/* design/dtbp_fmt.sv */
// result formatter: normalized exponent, overflow clamp, decimal digits, status
// depends on dtbp_pkg; maps dtbp_pkg::snap_t to dtbp_pkg::res_t
module dtbp_fmt (
  input  dtbp_pkg::snap_t snap_i,
  output dtbp_pkg::res_t  res_o
);
  import dtbp_pkg::*;

  localparam int EffW = 12;

  logic [EffW-1:0] pe;
  logic [EffW-1:0] eff;
  logic [EffW-1:0] mag;
  logic            eneg;
  logic            big;
  logic            ovf;
  logic [6:0]      mag7;
  logic [14:0]     prod;
  logic [3:0]      tens;
  logic [6:0]      rem7;

  always_comb begin
    pe = snap_i.written_exp_neg ? (EffW'(0) - EffW'(snap_i.written_exp))
                                : EffW'(snap_i.written_exp);
    if (snap_i.has_digits) begin
      eff = pe + EffW'(snap_i.point_pos) - EffW'(1) - EffW'(snap_i.frac_zeros);
    end else begin
      eff = '0;
    end
    eneg = eff[EffW-1];
    mag  = eneg ? (EffW'(0) - eff) : eff;
    big  = (|mag[EffW-1:7]) || (mag[6:0] > ExpMax);
    ovf  = big || (snap_i.has_digits &&
                   (snap_i.written_exp == ExpSat || snap_i.frac_zeros == LzSat));
    mag7 = ovf ? ExpMax : mag[6:0];
    prod = 15'(mag7) * 15'd205;
    tens = prod[14:11];
    rem7 = mag7 - {tens, 3'b000} - {2'b00, tens, 1'b0};

    res_o.negative          = snap_i.negative;
    res_o.mantissa_bcd      = snap_i.mantissa_bcd;
    res_o.exponent_negative = eneg;
    res_o.exponent_tens     = tens;
    res_o.exponent_units    = rem7[3:0];
    if (snap_i.too_many) begin
      res_o.status = StTooManyDig;
    end else if (ovf) begin
      res_o.status = StExpOverflow;
    end else begin
      res_o.status = StOk;
    end
  end

endmodule

/* design/decimal_text_to_bcd_float_parser.sv */
// Decimal text to BCD float parser. Takes one ASCII character per cycle; a
// character marked last closes the number; its snapshot is registered, then
// formatted into the result register, from which a result with the sign, 16
// packed BCD mantissa digits, the exponent sign and two exponent digits and a
// status appears on the result channel. The scanner state updates once per
// character, so text streams at one character per cycle with no gap between
// numbers; the end-of-number snapshot register and the result register keep
// the character side running while a result waits. The character channel
// stalls only when both of those hold an unread number.
// depends on dtbp_pkg, dtbp_if, dtbp_scan, dtbp_fmt and the assertion header
module decimal_text_to_bcd_float_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtbp_char_if.sink  in_i,
  dtbp_res_if.source out_o
);
  import dtbp_pkg::*;

  `include "decimal_text_to_bcd_float_parser_assert.svh"

  logic  accept;
  logic  out_free;
  logic  snap_free;
  snap_t snap_next;
  snap_t snap_q;
  logic  snap_valid_q;
  res_t  res_next;
  res_t  out_q;
  logic  out_valid_q;

  assign out_free  = !out_valid_q || out_o.ready;
  assign snap_free = !snap_valid_q || out_free;
  assign in_i.ready = snap_free;
  assign accept    = in_i.valid && snap_free;

  dtbp_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .char_code_i (in_i.char_code),
    .last_char_i (in_i.last_char),
    .snap_o      (snap_next)
  );

  dtbp_fmt u_fmt (
    .snap_i (snap_q),
    .res_o  (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (snap_free) begin
        snap_valid_q <= accept && in_i.last_char;
      end
      if (out_free) begin
        out_valid_q <= snap_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.last_char) begin
      snap_q <= snap_next;
    end
    if (out_free && snap_valid_q) begin
      out_q <= res_next;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.negative          = out_q.negative;
  assign out_o.mantissa_bcd      = out_q.mantissa_bcd;
  assign out_o.exponent_negative = out_q.exponent_negative;
  assign out_o.exponent_tens     = out_q.exponent_tens;
  assign out_o.exponent_units    = out_q.exponent_units;
  assign out_o.status            = out_q.status;

  `DTBP_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_o.valid, "result valid during reset")
  `DTBP_ASSERT(a_stall_when_full, (snap_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready, "request taken with both stages full")
  `DTBP_ASSERT(a_last_makes_snap, (in_i.valid && in_i.ready && in_i.last_char) |=> snap_valid_q, "last character lost")
  `DTBP_ASSERT(a_exp_digits_bcd, out_valid_q |-> (out_o.exponent_tens <= 4'd9 && out_o.exponent_units <= 4'd9), "exponent digit out of range")
  `DTBP_ASSERT(a_status_code, out_valid_q |-> (out_q.status == StOk || out_q.status == StTooManyDig || out_q.status == StExpOverflow), "bad status code")

endmodule

/* tb/tb_decimal_text_to_bcd_float_parser.sv */
// testbench for the decimal text to bcd float parser: drives number text one character
// per request, predicts each result and checks it field by field
// depends on dtbp_pkg, dtbp_if and decimal_text_to_bcd_float_parser
`timescale 1ns / 100ps

module tb_decimal_text_to_bcd_float_parser;
  import dtbp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int RandomChars = 60;

  typedef logic [7:0] char_t;
  typedef char_t text_t[$];

  typedef enum logic [2:0] {
    PhStart,
    PhMant,
    PhExpSign,
    PhExpDigits,
    PhExpDone
  } scan_phase_e;

  logic clk_i;
  logic rst_ni;

  dtbp_char_if char_if ();
  dtbp_res_if  res_if ();

  decimal_text_to_bcd_float_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (res_if)
  );

  // scanner copy
  scan_phase_e scan_ph;
  logic [3:0]  mant_digit[MantDigits];
  int          mant_count;
  int          int_digits;
  bit          point_found;
  bit          nonzero_found;
  int          frac_zeros;
  int          exp_value;
  bit          exp_minus;
  bit          mant_minus;
  bit          digit_dropped;

  res_t pending_results[$];
  int   error_count = 0;
  int   cycle_count = 0;
  bit   gaps_on = 1'b1;
  int   hold_req = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_digit(char_t c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic void clear_scan();
    scan_ph = PhStart;
    for (int i = 0; i < MantDigits; i++) mant_digit[i] = '0;
    mant_count    = 0;
    int_digits    = 0;
    point_found   = 1'b0;
    nonzero_found = 1'b0;
    frac_zeros    = 0;
    exp_value     = 0;
    exp_minus     = 1'b0;
    mant_minus    = 1'b0;
    digit_dropped = 1'b0;
  endfunction

  function automatic void scan_mantissa_char(char_t c);
    logic [3:0] d;
    if (c == CharLowerE || c == CharUpperE) begin
      scan_ph = PhExpSign;
      return;
    end
    scan_ph = PhMant;
    if (c == CharPoint) begin
      point_found = 1'b1;
      int_digits  = mant_count;
      return;
    end
    if (!is_digit(c)) return;
    d = 4'(c - CharZero);
    if (d == 4'd0 && !nonzero_found) begin
      if (point_found && frac_zeros < int'(LzSat)) frac_zeros++;
      return;
    end
    nonzero_found = 1'b1;
    if (mant_count >= MantDigits) begin
      digit_dropped = 1'b1;
      return;
    end
    mant_digit[mant_count] = d;
    mant_count++;
  endfunction

  function automatic void scan_exponent_digit(char_t c);
    int v;
    v = exp_value * 10 + int'(c - CharZero);
    exp_value = (v > int'(ExpSat)) ? int'(ExpSat) : v;
    scan_ph = PhExpDigits;
  endfunction

  // advances the scanner by one character; on the last one builds the result
  function automatic void parse_char(input char_t c, input bit last, output bit emits,
                                     output res_t r);
    logic [MantW-1:0] mant;
    int eff, mag, dbp, pe;
    bit ovf;
    case (scan_ph)
      PhStart: begin
        if (c == CharMinus) begin
          mant_minus = 1'b1;
          scan_ph = PhMant;
        end else if (c == CharPlus) begin
          scan_ph = PhMant;
        end else begin
          scan_mantissa_char(c);
        end
      end
      PhMant: scan_mantissa_char(c);
      PhExpSign: begin
        if (c == CharMinus) begin
          exp_minus = 1'b1;
          scan_ph = PhExpDigits;
        end else if (c == CharPlus) begin
          scan_ph = PhExpDigits;
        end else if (is_digit(c)) begin
          scan_exponent_digit(c);
        end else begin
          scan_ph = PhExpDone;
        end
      end
      PhExpDigits: begin
        if (is_digit(c)) scan_exponent_digit(c);
        else scan_ph = PhExpDone;
      end
      default: ;
    endcase

    emits = last;
    r = '0;
    if (!last) return;

    mant = '0;
    for (int i = 0; i < mant_count; i++) mant[MantW-1-4*i -: 4] = mant_digit[i];
    eff = 0;
    ovf = 1'b0;
    if (mant_count > 0) begin
      dbp = point_found ? int_digits : mant_count;
      pe  = exp_minus ? -exp_value : exp_value;
      eff = pe + dbp - 1 - frac_zeros;
      if (exp_value >= int'(ExpSat) || frac_zeros >= int'(LzSat)) ovf = 1'b1;
    end
    r.exponent_negative = (eff < 0);
    mag = (eff < 0) ? -eff : eff;
    if (mag > int'(ExpMax)) ovf = 1'b1;
    if (ovf) mag = int'(ExpMax);

    r.negative       = mant_minus;
    r.mantissa_bcd   = mant;
    r.exponent_tens  = 4'(mag / 10);
    r.exponent_units = 4'(mag % 10);
    if (digit_dropped) r.status = StTooManyDig;
    else if (ovf) r.status = StExpOverflow;
    else r.status = StOk;
    clear_scan();
  endfunction

  always @(posedge clk_i) begin : predict_results
    res_t r;
    bit   emits;
    if (rst_ni && char_if.valid && char_if.ready) begin
      parse_char(char_if.char_code, char_if.last_char, emits, r);
      if (emits) pending_results.push_back(r);
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending number");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.negative !== want.negative) begin
          $error("negative: expected %0d, got %0d", want.negative, res_if.negative);
          error_count++;
        end
        if (res_if.mantissa_bcd !== want.mantissa_bcd) begin
          $error("mantissa_bcd: expected %h, got %h", want.mantissa_bcd,
                 res_if.mantissa_bcd);
          error_count++;
        end
        if (res_if.exponent_negative !== want.exponent_negative) begin
          $error("exponent_negative: expected %0d, got %0d", want.exponent_negative,
                 res_if.exponent_negative);
          error_count++;
        end
        if (res_if.exponent_tens !== want.exponent_tens) begin
          $error("exponent_tens: expected %0d, got %0d", want.exponent_tens,
                 res_if.exponent_tens);
          error_count++;
        end
        if (res_if.exponent_units !== want.exponent_units) begin
          $error("exponent_units: expected %0d, got %0d", want.exponent_units,
                 res_if.exponent_units);
          error_count++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          error_count++;
        end
      end
    end
  end

  // result side: random stall per result, plus long holds on request
  initial begin : result_receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (res_if.valid && res_if.ready) stall_left = gaps_on ? $urandom_range(0, 4) : 0;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("decimal_text_to_bcd_float_parser verification failed");
      $finish;
    end
  end

  task automatic send_char(input char_t c, input bit last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.last_char <= last;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  task automatic send_str(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic char_t random_digit();
    return char_t'(CharZero + $urandom_range(0, 9));
  endfunction

  function automatic text_t random_number();
    text_t t;
    int    n_int;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) t.push_back(char_t'($urandom_range(0, 255)));
      return t;
    end
    case ($urandom_range(0, 3))
      0: t.push_back(CharMinus);
      1: t.push_back(CharPlus);
      default: ;
    endcase
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) t.push_back(CharZero);
    n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
    repeat (n_int) t.push_back(random_digit());
    if ($urandom_range(0, 15) == 0) t.push_back(char_t'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) < 7) begin
      t.push_back(CharPoint);
      repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0) t.push_back(CharZero);
      repeat ($urandom_range(0, 8)) t.push_back(random_digit());
      if ($urandom_range(0, 19) == 0) t.push_back(CharPoint);
    end
    if ($urandom_range(0, 1) == 1) begin
      t.push_back($urandom_range(0, 1) ? CharLowerE : CharUpperE);
      case ($urandom_range(0, 2))
        0: t.push_back(CharMinus);
        1: t.push_back(CharPlus);
        default: ;
      endcase
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3))
        t.push_back(random_digit());
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) t.push_back(char_t'($urandom_range(0, 255)));
    if (t.size() == 0) t.push_back(random_digit());
    return t;
  endfunction

  task automatic test_plain_numbers();
    send_str("0");
    send_str("7");
    send_str("-1.5");
    send_str("+42");
    send_str("3.14159e+2");
    send_str(".5");
    send_str("5.");
  endtask

  task automatic test_leading_zeros();
    send_str("000.000123");
    send_str("00120");
    send_str("0.0e5");
    send_str("-0.000");
  endtask

  task automatic test_stray_characters();
    text_t t;
    send_str("1x2-3+4");
    send_str("1.2.3");
    send_str("..5");
    send_str("e");
    send_str("E12");
    send_str("-");
    send_str("+e-");
    t = '{8'h31, 8'hFF, 8'h00, 8'h32, 8'hAA, 8'h55};
    send_text(t);
  endtask

  task automatic test_exponent_forms();
    send_str("1e5x9");
    send_str("2E-3.7e4");
    send_str("1e-");
    send_str("1e+");
    send_str("1ex5");
    send_str("9e007");
    send_str("1.5e-3");
  endtask

  task automatic test_digit_overflow();
    send_str("1234567890123456");
    send_str("12345678901234567");
    send_str("0.00098765432109876543");
    send_str("99999999999999999e200");
  endtask

  task automatic test_exponent_overflow();
    text_t t;
    send_str("1e99");
    send_str("1e100");
    send_str("10e99");
    send_str("1e-99");
    send_str("1e-100");
    send_str("1e1023");
    send_str("1e99999");
    send_str("-1e-1023");
    send_str("0e99999");
    // fraction zeros reaching and passing saturation
    t = '{CharZero, CharPoint};
    repeat (255) t.push_back(CharZero);
    t.push_back(CharNine);
    send_text(t);
    t = '{CharPoint};
    repeat (300) t.push_back(CharZero);
    t.push_back(CharZero + 8'd5);
    send_text(t);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (20) send_text(random_number());
    gaps_on = 1'b1;
  endtask

  task automatic test_result_backpressure();
    gaps_on  = 1'b0;
    hold_req = 300;
    send_str("123.45e6");
    send_str("-7");
    send_str("0.5");
    send_str("8e-2");
    send_str("+66");
    send_str("1");
    repeat (10) send_text(random_number());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_text();
    text_t t;
    int    sent;
    sent = 0;
    while (sent < RandomChars) begin
      gaps_on = ($urandom_range(0, 7) != 0);
      t = random_number();
      send_text(t);
      sent += t.size();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_scan();
    rst_ni            <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    char_if.last_char <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_numbers();
    test_leading_zeros();
    test_stray_characters();
    test_exponent_forms();
    test_digit_overflow();
    test_exponent_overflow();
    test_back_to_back();
    test_result_backpressure();
    test_random_text();

    char_if.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("decimal_text_to_bcd_float_parser verification clean");
    end else begin
      $display("decimal_text_to_bcd_float_parser verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/dtbp_pkg.sv
design/dtbp_if.sv
design/dtbp_scan.sv
design/dtbp_fmt.sv
design/decimal_text_to_bcd_float_parser.sv
tb/tb_decimal_text_to_bcd_float_parser.sv
